/* hw/rtl/set_membership_table_top_assert.svh */
// Assertion macros used by the checker file of the set membership table.
`ifndef SET_MEMBERSHIP_TABLE_TOP_ASSERT_SVH
`define SET_MEMBERSHIP_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define SMT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("set membership table check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define SMT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("set membership table check failed");

`endif

/* hw/rtl/smt_pkg.sv */
// Package with the shared types and constants of the set membership table.
package smt_pkg;

    localparam int NUM_SETS_DEF     = 32;
    localparam int NUM_ELEMENTS_DEF = 64;

    localparam int OP_W    = 3;
    localparam int SET_W   = 5;
    localparam int ELEM_W  = 6;
    localparam int VALUE_W = 6;

    typedef enum logic [OP_W-1:0] {
        OP_ADD          = 3'd0,
        OP_REMOVE       = 3'd1,
        OP_CLEAR        = 3'd2,
        OP_LIST_SET     = 3'd3,
        OP_LIST_SETS_OF = 3'd4
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic load;
        logic step;
        logic emit;
    } smt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cur_bit;
        logic rest_zero;
        logic empty;
        logic out_free;
    } smt_stat_t;

endpackage

/* hw/rtl/smt_cmd_if.sv */
// Command channel interface of the set membership table.
interface smt_cmd_if
    import smt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [SET_W-1:0]  set_index;
    logic [ELEM_W-1:0] element;

    modport source (output valid, output op, output set_index, output element, input ready);
    modport sink   (input valid, input op, input set_index, input element, output ready);
endinterface

/* hw/rtl/smt_res_if.sv */
// Result channel interface of the set membership table.
interface smt_res_if
    import smt_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] item_value;
    logic               is_empty;
    logic               last;

    modport source (output valid, output item_value, output is_empty, output last, input ready);
    modport sink   (input valid, input item_value, input is_empty, input last, output ready);
endinterface

/* hw/rtl/smt_ctrl.sv */
// Controller state machine: command acceptance and listing walk sequencing.
module smt_ctrl
    import smt_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [OP_W-1:0] op,
    output logic            in_ready,
    input  smt_stat_t       stat,
    output smt_cmd_t        cmd
);

    state_t state_reg;
    state_t state_next;
    logic   is_list;
    logic   want;
    logic   fire;
    logic   last_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        is_list    = op inside {OP_LIST_SET, OP_LIST_SETS_OF};
        want       = stat.empty || stat.cur_bit;
        fire       = want && stat.out_free;
        last_item  = stat.empty || stat.rest_zero;
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                cmd.load   = in_valid && is_list;
                if (in_valid && is_list)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                // Skip clear bits; a member waits until the output register is free.
                cmd.emit = fire;
                cmd.step = !want || (fire && !last_item);
                if (fire && last_item)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/smt_datapath.sv */
// Datapath: membership bit matrix, listing shift register and output register.
module smt_datapath
    import smt_pkg::*;
#(
    parameter int NUM_SETS     = NUM_SETS_DEF,
    parameter int NUM_ELEMENTS = NUM_ELEMENTS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [OP_W-1:0]    op,
    input  logic [SET_W-1:0]   set_index,
    input  logic [ELEM_W-1:0]  element,
    input  smt_cmd_t           cmd,
    output smt_stat_t          stat,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [VALUE_W-1:0] item_value,
    output logic               is_empty,
    output logic               last
);

    localparam int SIW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int EIW = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
    localparam int LW  = (NUM_SETS > NUM_ELEMENTS) ? NUM_SETS : NUM_ELEMENTS;
    localparam int CW  = 7;

    logic [NUM_ELEMENTS-1:0] rows_reg  [NUM_SETS];
    logic [NUM_ELEMENTS-1:0] rows_next [NUM_SETS];
    logic [LW-1:0]           vec_reg;
    logic [LW-1:0]           vec_next;
    logic [VALUE_W-1:0]      idx_reg;
    logic [VALUE_W-1:0]      idx_next;
    logic                    empty_reg;
    logic                    empty_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [VALUE_W-1:0]      item_value_reg;
    logic [VALUE_W-1:0]      item_value_next;
    logic                    is_empty_reg;
    logic                    is_empty_next;
    logic                    last_reg;
    logic                    last_next;

    logic [CW-1:0]           s_ext;
    logic [CW-1:0]           e_ext;
    logic                    s_ok;
    logic                    e_ok;
    logic [SIW-1:0]          row;
    logic [EIW-1:0]          col;
    logic [NUM_SETS-1:0]     col_vec;
    logic [LW-1:0]           sel_vec;

    assign s_ext = CW'(set_index);
    assign e_ext = CW'(element);
    assign s_ok  = s_ext < CW'(NUM_SETS);
    assign e_ok  = e_ext < CW'(NUM_ELEMENTS);
    assign row   = s_ext[SIW-1:0];
    assign col   = e_ext[EIW-1:0];

    // The sets that hold the addressed element, one bit per set.
    for (genvar s = 0; s < NUM_SETS; s++)
    begin : g_col
        assign col_vec[s] = rows_reg[s][col];
    end

    always_comb
    begin
        sel_vec = '0;
        case (op_t'(op))
            OP_LIST_SET:
            begin
                if (s_ok)
                begin
                    sel_vec = LW'(rows_reg[row]);
                end
            end
            OP_LIST_SETS_OF:
            begin
                if (e_ok)
                begin
                    sel_vec = LW'(col_vec);
                end
            end
            default:
            begin
                sel_vec = '0;
            end
        endcase
    end

    // Table updates happen at the edge where the command is taken.
    always_comb
    begin
        rows_next = rows_reg;
        if (cmd.accept)
        begin
            case (op_t'(op))
                OP_ADD:
                begin
                    if (s_ok && e_ok)
                    begin
                        rows_next[row][col] = 1'b1;
                    end
                end
                OP_REMOVE:
                begin
                    if (s_ok && e_ok)
                    begin
                        rows_next[row][col] = 1'b0;
                    end
                end
                OP_CLEAR:
                begin
                    if (s_ok)
                    begin
                        rows_next[row] = '0;
                    end
                end
                default:
                begin
                    rows_next = rows_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        vec_next   = vec_reg;
        idx_next   = idx_reg;
        empty_next = empty_reg;
        if (cmd.load)
        begin
            vec_next   = sel_vec;
            idx_next   = '0;
            empty_next = (sel_vec == '0);
        end
        else if (cmd.step)
        begin
            vec_next = vec_reg >> 1;
            idx_next = idx_reg + VALUE_W'(1);
        end
    end

    assign stat.cur_bit   = vec_reg[0];
    assign stat.rest_zero = ((vec_reg >> 1) == '0);
    assign stat.empty     = empty_reg;
    assign stat.out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg && !out_ready;
        item_value_next = item_value_reg;
        is_empty_next   = is_empty_reg;
        last_next       = last_reg;
        if (cmd.emit)
        begin
            out_valid_next  = 1'b1;
            item_value_next = empty_reg ? '0 : idx_reg;
            is_empty_next   = empty_reg;
            last_next       = empty_reg || stat.rest_zero;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_SETS; s++)
            begin
                rows_reg[s] <= '0;
            end
            vec_reg       <= '0;
            idx_reg       <= '0;
            empty_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rows_reg      <= rows_next;
            vec_reg       <= vec_next;
            idx_reg       <= idx_next;
            empty_reg     <= empty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_value_reg <= item_value_next;
        is_empty_reg   <= is_empty_next;
        last_reg       <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign item_value = item_value_reg;
    assign is_empty   = is_empty_reg;
    assign last       = last_reg;

endmodule

/* hw/rtl/set_membership_table_top.sv */
// Top level of the set membership table: controller and datapath wired to the channels.
//
// The block keeps a membership relation between up to NUM_SETS numbered sets
// and NUM_ELEMENTS element values. Commands arrive on the cmd channel, one per
// transfer: add, remove, clear set, list the members of a set, or list the
// sets that hold an element. Results leave on the res channel, one transfer
// per listed member in ascending order, the final one flagged by last. An
// empty listing gives a single transfer with is_empty and last set.
// Add, remove and clear take effect at the edge of their transfer and give no
// result; the next command is taken in the following cycle. Any other op code
// is dropped without effect.
// A listing walks its bit vector one position per cycle in a shift register,
// except while a member waits for the output register; the walk runs up to
// and including the highest member, and no new command is taken meanwhile.
// The first result is offered at the earliest once the command has been
// loaded into the shift register and its first member into the output register.
// A result waits in the output register while the receiver stalls; the walk
// holds on the next member until that register frees up, and a new command is
// taken as soon as the walk has handed over its last result.
// Reset clears the whole table and drops any pending result.
module set_membership_table_top
    import smt_pkg::*;
#(
    parameter int NUM_SETS     = NUM_SETS_DEF,
    parameter int NUM_ELEMENTS = NUM_ELEMENTS_DEF
)
(
    input logic       clk,
    input logic       rst_n,
    smt_cmd_if.sink   cmd,
    smt_res_if.source res
);

    smt_cmd_t ctl_cmd;
    smt_stat_t dp_stat;

    // The controller owns the command handshake and the walk sequencing.
    smt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .op       (cmd.op),
        .in_ready (cmd.ready),
        .stat     (dp_stat),
        .cmd      (ctl_cmd)
    );

    // The datapath holds the table, the walk register and the result register.
    smt_datapath #(
        .NUM_SETS     (NUM_SETS),
        .NUM_ELEMENTS (NUM_ELEMENTS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (cmd.op),
        .set_index  (cmd.set_index),
        .element    (cmd.element),
        .cmd        (ctl_cmd),
        .stat       (dp_stat),
        .out_ready  (res.ready),
        .out_valid  (res.valid),
        .item_value (res.item_value),
        .is_empty   (res.is_empty),
        .last       (res.last)
    );

endmodule

/* hw/rtl/smt_checker.sv */
// Port-level checker of the set membership table and its bind to the top level.
`include "set_membership_table_top_assert.svh"

module smt_checker
    import smt_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               res_valid,
    input logic               res_ready,
    input logic [VALUE_W-1:0] res_item_value,
    input logic               res_is_empty,
    input logic               res_last
);

    // A stalled result stays offered.
    `SMT_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid)

    // A stalled result keeps its payload.
    `SMT_ASSERT_NXT(a_res_stable, res_valid && !res_ready,
        $stable(res_item_value) && $stable(res_is_empty) && $stable(res_last))

    // An empty listing is a single zero-valued result.
    `SMT_ASSERT_IMP(a_empty_form, res_valid && res_is_empty,
        res_last && (res_item_value == '0))

    // Within one listing the values rise strictly.
    `SMT_ASSERT_NXT(a_ascending, res_valid && res_ready && !res_last,
        !res_valid || (!res_is_empty && (res_item_value > $past(res_item_value))))

endmodule

bind set_membership_table_top smt_checker u_smt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .res_item_value (res.item_value),
    .res_is_empty   (res.is_empty),
    .res_last       (res.last)
);
